// File: hw/rtl/cfir_pkg.sv
// ----------------------------------------------------------------------------
// cfir_pkg : shared types and constants of the complex I/Q FIR core
// Sample, coefficient, product and accumulator types, opcodes, lane layout
// and the Q30 scale-and-saturate function.
// ----------------------------------------------------------------------------
`default_nettype none

package cfir_pkg;

   // Tap count and lane layout
   localparam int TAPS     = 31;
   localparam int LANES    = 4;
   localparam int ROUNDS   = (TAPS + LANES - 1) / LANES;
   localparam int SLOTS    = LANES * ROUNDS;
   localparam int CNT_W    = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;

   // Field widths
   localparam int SAMPLE_W = 16;
   localparam int COEF_W   = 32;
   localparam int PROD_W   = SAMPLE_W + COEF_W;
   localparam int ACC_W    = PROD_W + $clog2(SLOTS);
   localparam int Q_SHIFT  = 30;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [COEF_W-1:0]   coef_type;
   typedef logic signed [PROD_W-1:0]   prod_type;
   typedef logic signed [ACC_W-1:0]    acc_type;
   typedef logic        [1:0]          opcode_type;
   typedef logic        [4:0]          coef_index_type;

   // Opcodes
   localparam opcode_type OP_FILTER = 2'd0;
   localparam opcode_type OP_LOAD   = 2'd1;
   localparam opcode_type OP_CLEAR  = 2'd2;

   // Sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   // Control from the sequencer to the merge stage
   typedef struct packed {
      logic clear;
      logic add;
   } merge_ctrl_type;

   localparam acc_type    ACC_BIAS    = ACC_W'((1 << Q_SHIFT) - 1);
   localparam acc_type    SAT_MAX_ACC = ACC_W'(32767);
   localparam acc_type    SAT_MIN_ACC = ACC_W'(-32768);
   localparam sample_type SAT_MAX     = 16'sh7fff;
   localparam sample_type SAT_MIN     = 16'sh8000;

   // Shift right by Q_SHIFT rounding toward zero, then clamp to 16 bits
   function automatic sample_type scale_sat(acc_type acc);
      acc_type biased;
      acc_type shifted;
      biased  = acc + (acc[ACC_W-1] ? ACC_BIAS : acc_type'(0));
      shifted = biased >>> Q_SHIFT;
      if (shifted > SAT_MAX_ACC) begin
         return SAT_MAX;
      end
      if (shifted < SAT_MIN_ACC) begin
         return SAT_MIN;
      end
      return sample_type'(shifted[SAMPLE_W-1:0]);
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/complex_fir_q30_saturating_core.sv
// ----------------------------------------------------------------------------
// complex_fir_q30_saturating_core : complex I/Q FIR, Q30 taps, 16-bit clamp
// Tap line and coefficient line, four multiplier lanes, merge accumulator,
// sequencer, one pending result and an output register.
//
//   channel   ports                         direction  transfer when
//   request   req_valid / req_stall / req_*  in         valid & !stall
//   response  rsp_valid / rsp_stall / rsp_*  out        valid & !stall
//   control   csr_we / csr_wdata             in         csr_we
//
// A filter word blocks the input while the sequencer runs: the lines rotate
// past LANES lanes one group per round, the registered lane products are merged,
// and the scaled sum enters the pending register, then the output register.
// Bypass words pass through the pending register; loads and clears do not.
// Reset zeroes the tap and coefficient lines and sets bypass; no sweep.
// A waiting response holds its word; one more result may be pending behind it.
// ----------------------------------------------------------------------------
`default_nettype none

module complex_fir_q30_saturating_core (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       req_valid,
   output logic                      req_stall,
   input  cfir_pkg::opcode_type      req_opcode,
   input  cfir_pkg::sample_type      req_sample_i,
   input  cfir_pkg::sample_type      req_sample_q,
   input  cfir_pkg::coef_index_type  req_coef_index,
   input  cfir_pkg::coef_type        req_coef_value,
   input  wire                       req_batch_end,
   output logic                      rsp_valid,
   input  wire                       rsp_stall,
   output cfir_pkg::sample_type      rsp_filtered_i,
   output cfir_pkg::sample_type      rsp_filtered_q,
   output logic                      rsp_batch_end_out,
   input  wire                       csr_we,
   input  wire                       csr_wdata
);
   import cfir_pkg::*;

   localparam logic [CNT_W-1:0] ROUND_LAST = CNT_W'(ROUNDS - 1);

   state_type        state_ff;
   state_type        state_in;
   logic [CNT_W-1:0] round_ff;
   logic [CNT_W-1:0] round_in;
   logic             bypass_ff;
   logic             accept;
   logic             start;

   coef_type   coef_ff   [SLOTS];
   coef_type   coef_in   [SLOTS];
   sample_type hist_i_ff [SLOTS];
   sample_type hist_i_in [SLOTS];
   sample_type hist_q_ff [SLOTS];
   sample_type hist_q_in [SLOTS];

   prod_type       prod_i [LANES];
   prod_type       prod_q [LANES];
   logic           prod_vld_ff;
   acc_type        acc_i;
   acc_type        acc_q;
   merge_ctrl_type mctrl;

   logic       bend_ff;
   logic       pend_ff;
   logic       pend_in;
   sample_type pend_i_ff;
   sample_type pend_q_ff;
   logic       pend_bend_ff;
   logic       pend_load;
   logic       rsp_load;

   logic       rsp_valid_ff;
   sample_type rsp_i_ff;
   sample_type rsp_q_ff;
   logic       rsp_bend_ff;

   // Take a word only when idle with no result pending
   assign req_stall = (state_ff != ST_IDLE) || pend_ff;
   assign accept    = req_valid && !req_stall;
   assign start     = accept && (req_opcode == OP_FILTER) && !bypass_ff;

   // Bypass register
   always_ff @(posedge clock) begin
      if (reset) begin
         bypass_ff <= 1'b1;
      end else if (csr_we) begin
         bypass_ff <= csr_wdata;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_RUN;
         end
         ST_RUN: begin
            if (round_ff == ROUND_LAST) state_in = ST_DRAIN;
         end
         ST_DRAIN:  state_in = ST_FINISH;
         ST_FINISH: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs
   always_comb begin
      round_in    = round_ff;
      mctrl.clear = 1'b0;
      mctrl.add   = prod_vld_ff;
      case (state_ff)
         ST_IDLE: begin
            round_in    = '0;
            mctrl.clear = start;
         end
         ST_RUN: begin
            round_in = round_ff + CNT_W'(1);
         end
         default: begin
            round_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         round_ff    <= '0;
         prod_vld_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         round_ff    <= round_in;
         prod_vld_ff <= (state_ff == ST_RUN);
      end
   end

   // Tap and coefficient lines: load, shift in, clear, or rotate by one group
   always_comb begin
      for (int j = 0; j < SLOTS; j++) begin
         coef_in[j]   = coef_ff[j];
         hist_i_in[j] = hist_i_ff[j];
         hist_q_in[j] = hist_q_ff[j];
      end
      if (state_ff == ST_RUN) begin
         for (int j = 0; j < SLOTS; j++) begin
            coef_in[j]   = coef_ff[(j + LANES) % SLOTS];
            hist_i_in[j] = hist_i_ff[(j + LANES) % SLOTS];
            hist_q_in[j] = hist_q_ff[(j + LANES) % SLOTS];
         end
      end else if (accept) begin
         case (req_opcode)
            OP_LOAD: begin
               for (int j = 0; j < TAPS; j++) begin
                  if (32'(req_coef_index) == j) coef_in[j] = req_coef_value;
               end
            end
            OP_CLEAR: begin
               for (int j = 0; j < SLOTS; j++) begin
                  hist_i_in[j] = '0;
                  hist_q_in[j] = '0;
               end
            end
            OP_FILTER: begin
               if (!bypass_ff) begin
                  for (int j = 0; j < TAPS - 1; j++) begin
                     hist_i_in[j] = hist_i_ff[j + 1];
                     hist_q_in[j] = hist_q_ff[j + 1];
                  end
                  hist_i_in[TAPS-1] = req_sample_i;
                  hist_q_in[TAPS-1] = req_sample_q;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < SLOTS; j++) begin
            coef_ff[j]   <= '0;
            hist_i_ff[j] <= '0;
            hist_q_ff[j] <= '0;
         end
      end else begin
         for (int j = 0; j < SLOTS; j++) begin
            coef_ff[j]   <= coef_in[j];
            hist_i_ff[j] <= hist_i_in[j];
            hist_q_ff[j] <= hist_q_in[j];
         end
      end
   end

   // Multiplier lanes, each on a fixed slot of the rotating lines
   for (genvar k = 0; k < LANES; k++) begin : g_lane
      cfir_lane u_lane (
         .clock  (clock),
         .coef   (coef_ff[k]),
         .hist_i (hist_i_ff[k]),
         .hist_q (hist_q_ff[k]),
         .prod_i (prod_i[k]),
         .prod_q (prod_q[k])
      );
   end

   cfir_merge u_merge (
      .clock  (clock),
      .ctrl   (mctrl),
      .prod_i (prod_i),
      .prod_q (prod_q),
      .acc_i  (acc_i),
      .acc_q  (acc_q)
   );

   // Capture the batch marker of the word in flight
   always_ff @(posedge clock) begin
      if (start) bend_ff <= req_batch_end;
   end

   // Pending result: bypass word or scaled filter sum
   assign pend_load = accept && (req_opcode == OP_FILTER) && bypass_ff;
   assign rsp_load  = pend_ff && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      pend_in = pend_ff;
      if (pend_load || (state_ff == ST_FINISH)) begin
         pend_in = 1'b1;
      end else if (rsp_load) begin
         pend_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pend_load) begin
         pend_i_ff    <= req_sample_i;
         pend_q_ff    <= req_sample_q;
         pend_bend_ff <= req_batch_end;
      end else if (state_ff == ST_FINISH) begin
         pend_i_ff    <= scale_sat(acc_i);
         pend_q_ff    <= scale_sat(acc_q);
         pend_bend_ff <= bend_ff;
      end
   end

   // Output register: hold while stalled, advance from pending
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_i_ff    <= pend_i_ff;
         rsp_q_ff    <= pend_q_ff;
         rsp_bend_ff <= pend_bend_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_filtered_i    = rsp_i_ff;
   assign rsp_filtered_q    = rsp_q_ff;
   assign rsp_batch_end_out = rsp_bend_ff;

   // Checks
   a_finish_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH) |-> !pend_ff)
      else $error("filter result would overwrite a pending word");

   a_round_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (round_ff <= ROUND_LAST))
      else $error("round counter past last slot group");

   a_drain_merge: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN) |-> prod_vld_ff)
      else $error("last lane products not merged");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> (rsp_valid_ff && $stable(rsp_i_ff)
         && $stable(rsp_q_ff)))
      else $error("stalled response word changed");

endmodule

`default_nettype wire

// File: hw/rtl/cfir_lane.sv
// ----------------------------------------------------------------------------
// cfir_lane : one complex tap multiplier
// Multiplies one coefficient by the I and Q history entries of its slot and
// registers both products.
// ----------------------------------------------------------------------------
`default_nettype none

module cfir_lane (
   input  wire                  clock,
   input  cfir_pkg::coef_type   coef,
   input  cfir_pkg::sample_type hist_i,
   input  cfir_pkg::sample_type hist_q,
   output cfir_pkg::prod_type   prod_i,
   output cfir_pkg::prod_type   prod_q
);
   import cfir_pkg::*;

   prod_type prod_i_ff;
   prod_type prod_q_ff;

   // Register both real products of this slot
   always_ff @(posedge clock) begin
      prod_i_ff <= prod_type'(coef) * prod_type'(hist_i);
      prod_q_ff <= prod_type'(coef) * prod_type'(hist_q);
   end

   assign prod_i = prod_i_ff;
   assign prod_q = prod_q_ff;

endmodule

`default_nettype wire

// File: hw/rtl/cfir_merge.sv
// ----------------------------------------------------------------------------
// cfir_merge : lane merge and accumulator
// Adds the registered products of all lanes into the I and Q accumulators
// once per round.
// ----------------------------------------------------------------------------
`default_nettype none

module cfir_merge (
   input  wire                       clock,
   input  cfir_pkg::merge_ctrl_type  ctrl,
   input  cfir_pkg::prod_type        prod_i [cfir_pkg::LANES],
   input  cfir_pkg::prod_type        prod_q [cfir_pkg::LANES],
   output cfir_pkg::acc_type         acc_i,
   output cfir_pkg::acc_type         acc_q
);
   import cfir_pkg::*;

   acc_type acc_i_ff;
   acc_type acc_q_ff;
   acc_type acc_i_in;
   acc_type acc_q_in;

   // Sum the lanes onto the running totals
   always_comb begin
      acc_type sum_i;
      acc_type sum_q;
      sum_i = acc_i_ff;
      sum_q = acc_q_ff;
      for (int k = 0; k < LANES; k++) begin
         sum_i = sum_i + acc_type'(prod_i[k]);
         sum_q = sum_q + acc_type'(prod_q[k]);
      end
      acc_i_in = acc_i_ff;
      acc_q_in = acc_q_ff;
      if (ctrl.clear) begin
         acc_i_in = '0;
         acc_q_in = '0;
      end else if (ctrl.add) begin
         acc_i_in = sum_i;
         acc_q_in = sum_q;
      end
   end

   always_ff @(posedge clock) begin
      acc_i_ff <= acc_i_in;
      acc_q_ff <= acc_q_in;
   end

   assign acc_i = acc_i_ff;
   assign acc_q = acc_q_ff;

endmodule

`default_nettype wire

// File: bench/complex_fir_q30_saturating_core_tb.sv
// ----------------------------------------------------------------------------
// complex_fir_q30_saturating_core_tb : self-checking bench for the I/Q FIR
// Sends filter, coefficient-load, history-clear and unused-opcode words under
// random sender gaps and receiver stalls. A local model of the tap history,
// coefficient table and bypass bit predicts every output word, and the
// checker compares each accepted output against the oldest prediction.
// ----------------------------------------------------------------------------

module complex_fir_q30_saturating_core_tb;

   timeunit 1ns;
   timeprecision 1ps;

   import cfir_pkg::*;

   localparam opcode_type OP_UNUSED = 2'd3;
   localparam int         HOLD_CYCLES = 300;

   typedef struct {
      sample_type fi;
      sample_type fq;
      logic       be;
   } filtered_word_type;

   // DUT ports
   logic           clock;
   logic           reset;
   logic           req_valid;
   logic           req_stall;
   opcode_type     req_opcode;
   sample_type     req_sample_i;
   sample_type     req_sample_q;
   coef_index_type req_coef_index;
   coef_type       req_coef_value;
   logic           req_batch_end;
   logic           rsp_valid;
   logic           rsp_stall;
   sample_type     rsp_filtered_i;
   sample_type     rsp_filtered_q;
   logic           rsp_batch_end_out;
   logic           csr_we;
   logic           csr_wdata;

   // Local copy of the filter state
   sample_type     tap_hist_i [TAPS];
   sample_type     tap_hist_q [TAPS];
   coef_type       tap_coef   [TAPS];
   int             tap_ptr;
   logic           bypass_on;

   filtered_word_type expected_iq [$];
   filtered_word_type oldest;
   int             fail_count;

   // Sender and receiver pacing
   bit             sender_gaps;
   int             burst_left;
   bit             hold_request;
   int             hold_left;
   int             stall_mode;
   int             mode_left;
   int             run_left;
   bit             run_stall;

   complex_fir_q30_saturating_core u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_opcode        (req_opcode),
      .req_sample_i      (req_sample_i),
      .req_sample_q      (req_sample_q),
      .req_coef_index    (req_coef_index),
      .req_coef_value    (req_coef_value),
      .req_batch_end     (req_batch_end),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_filtered_i    (rsp_filtered_i),
      .rsp_filtered_q    (rsp_filtered_q),
      .rsp_batch_end_out (rsp_batch_end_out),
      .csr_we            (csr_we),
      .csr_wdata         (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop in case the block hangs
   initial begin
      #2_000_000;
      $display("simulation failed");
      $finish;
   end

   // Shift by 30 toward zero, then clamp to 16 bits
   function automatic sample_type q30_clamp(longint acc);
      longint q;
      if (acc >= 0) begin
         q = acc >>> 30;
      end else begin
         q = -((-acc) >>> 30);
      end
      if (q > 32767) begin
         return 16'sh7fff;
      end
      if (q < -32768) begin
         return 16'sh8000;
      end
      return sample_type'(q);
   endfunction

   // Advance the local state by one accepted word and queue its output
   task automatic model_word(opcode_type op, sample_type si, sample_type sq,
                             coef_index_type ci, coef_type cv, logic be);
      longint            acc_i;
      longint            acc_q;
      int                pos;
      filtered_word_type w;
      acc_i = 0;
      acc_q = 0;
      case (op)
         OP_LOAD: begin
            if (ci < TAPS) begin
               tap_coef[ci] = cv;
            end
         end
         OP_CLEAR: begin
            for (int t = 0; t < TAPS; t++) begin
               tap_hist_i[t] = '0;
               tap_hist_q[t] = '0;
            end
            tap_ptr = 0;
         end
         OP_FILTER: begin
            if (bypass_on) begin
               w.fi = si;
               w.fq = sq;
            end else begin
               tap_hist_i[tap_ptr] = si;
               tap_hist_q[tap_ptr] = sq;
               tap_ptr = (tap_ptr + 1) % TAPS;
               // coefficient 0 meets the oldest sample, just past the pointer
               pos = tap_ptr;
               for (int t = 0; t < TAPS; t++) begin
                  acc_i += longint'(tap_coef[t]) * longint'(tap_hist_i[pos]);
                  acc_q += longint'(tap_coef[t]) * longint'(tap_hist_q[pos]);
                  pos = (pos + 1 == TAPS) ? 0 : pos + 1;
               end
               w.fi = q30_clamp(acc_i);
               w.fq = q30_clamp(acc_q);
            end
            w.be = be;
            expected_iq.push_back(w);
         end
         default: begin
         end
      endcase
   endtask

   // Offer one word, hold it until taken, then update the model
   task automatic send_word(opcode_type op, sample_type si, sample_type sq,
                            coef_index_type ci, coef_type cv, logic be);
      int gap;
      gap = 0;
      if (sender_gaps) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap        = $urandom_range(1, 8);
         end
         burst_left--;
      end
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid      <= 1'b1;
      req_opcode     <= op;
      req_sample_i   <= si;
      req_sample_q   <= sq;
      req_coef_index <= ci;
      req_coef_value <= cv;
      req_batch_end  <= be;
      do begin
         @(posedge clock);
      end while (!(req_valid && !req_stall));
      model_word(op, si, sq, ci, cv, be);
   endtask

   // Drop valid and wait until every predicted word is out
   task automatic drain_outputs();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_iq.size() != 0) begin
         @(posedge clock);
      end
      repeat (20) @(posedge clock);
   endtask

   task automatic write_bypass(logic value);
      drain_outputs();
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
      bypass_on = value;
   endtask

   function automatic sample_type rand_sample();
      case ($urandom_range(0, 9))
         0:       return 16'sh7fff;
         1:       return 16'sh8000;
         2:       return ($urandom_range(0, 1) == 0) ? 16'sh0000 : 16'shffff;
         default: return sample_type'($urandom);
      endcase
   endfunction

   // Mostly modest taps so outputs stay inside the clamp, some full scale
   function automatic coef_type rand_coef();
      case ($urandom_range(0, 9))
         0:       return coef_type'($urandom);
         1:       return ($urandom_range(0, 1) == 0) ? 32'sh7fffffff : 32'sh80000000;
         default: return coef_type'(int'($urandom_range(0, 2**27 - 1)) - 2**26);
      endcase
   endfunction

   task automatic send_random_word(bit filter_only);
      opcode_type op;
      int         pick;
      pick = $urandom_range(0, 99);
      if (filter_only || pick < 75) begin
         op = OP_FILTER;
      end else if (pick < 93) begin
         op = OP_LOAD;
      end else if (pick < 96) begin
         op = OP_CLEAR;
      end else begin
         op = OP_UNUSED;
      end
      send_word(op, rand_sample(), rand_sample(),
                coef_index_type'($urandom_range(0, 31)), rand_coef(),
                logic'($urandom_range(0, 1)));
   endtask

   // Samples pass untouched while bypass is set; loads and clears are silent
   task automatic test_bypass_passthrough();
      send_word(OP_FILTER, 16'sh7fff, 16'sh8000, 5'd0, 32'sd0, 1'b1);
      send_word(OP_FILTER, 16'sh8000, 16'sh7fff, 5'd31, 32'sh7fffffff, 1'b0);
      send_word(OP_FILTER, 16'sh0000, 16'shffff, 5'd21, 32'sh80000000, 1'b1);
      send_word(OP_FILTER, 16'sh5555, 16'shaaaa, 5'd10, 32'sh55555555, 1'b0);
      send_word(OP_UNUSED, 16'sh1234, 16'sh4321, 5'd3, 32'sd5, 1'b1);
      send_word(OP_LOAD, 16'sh0000, 16'sh0000, 5'd0, 32'sd0, 1'b0);
      send_word(OP_CLEAR, 16'shffff, 16'shffff, 5'd31, 32'shffffffff, 1'b1);
   endtask

   // Mostly single-tap checks: identity, clamping both ways, rounding toward zero
   task automatic test_fir_directed();
      write_bypass(1'b0);
      send_word(OP_LOAD, 16'sh0000, 16'sh0000, 5'd30, 32'sh40000000, 1'b0);
      send_word(OP_FILTER, 16'sh04d2, -16'sh162e, 5'd0, 32'sd0, 1'b1);
      send_word(OP_FILTER, 16'sh8000, 16'sh7fff, 5'd0, 32'sd0, 1'b0);
      send_word(OP_LOAD, 16'sh0000, 16'sh0000, 5'd30, 32'sh7fffffff, 1'b0);
      send_word(OP_FILTER, 16'sh7fff, 16'sh8000, 5'd0, 32'sd0, 1'b1);
      send_word(OP_LOAD, 16'sh0000, 16'sh0000, 5'd30, 32'sh80000000, 1'b0);
      send_word(OP_FILTER, 16'sh8000, 16'sh7fff, 5'd0, 32'sd0, 1'b0);
      send_word(OP_LOAD, 16'sh0000, 16'sh0000, 5'd30, 32'sh20000000, 1'b0);
      send_word(OP_FILTER, -16'sd3, 16'sd3, 5'd0, 32'sd0, 1'b1);
      send_word(OP_FILTER, -16'sd1, 16'sd1, 5'd0, 32'sd0, 1'b0);
      // oldest tap, plus a load past the last tap that must be dropped
      send_word(OP_LOAD, 16'sh0000, 16'sh0000, 5'd0, 32'sh40000000, 1'b0);
      send_word(OP_LOAD, 16'sh0000, 16'sh0000, 5'd31, 32'sh40000000, 1'b0);
      send_word(OP_FILTER, 16'sh0101, 16'sh0202, 5'd0, 32'sd0, 1'b1);
      send_word(OP_UNUSED, 16'sh7fff, 16'sh7fff, 5'd30, 32'sh7fffffff, 1'b1);
      send_word(OP_CLEAR, 16'sh0000, 16'sh0000, 5'd0, 32'sd0, 1'b0);
      send_word(OP_FILTER, 16'sh7fff, 16'sh8000, 5'd0, 32'sd0, 1'b1);
      send_word(OP_FILTER, 16'sh1111, 16'sh2222, 5'd0, 32'sd0, 1'b0);
   endtask

   // Random traffic over several bypass settings, with and without gaps
   task automatic test_random_traffic();
      for (int p = 0; p < 5; p++) begin
         write_bypass((p == 2 || p == 4) ? 1'b1 : 1'b0);
         sender_gaps = (p % 2 == 0);
         repeat (90) send_random_word(1'b0);
      end
      sender_gaps = 1'b1;
   endtask

   // Receiver holds off while filter words keep coming, so the input backs up
   task automatic test_output_backpressure();
      write_bypass(1'b0);
      sender_gaps  = 1'b0;
      hold_request = 1'b1;
      repeat (40) send_random_word(1'b1);
      sender_gaps = 1'b1;
   endtask

   // Receiver stall pattern, with an occasional long hold on request
   initial begin
      rsp_stall = 1'b0;
      hold_left = 0;
      mode_left = 0;
      run_left  = 0;
      run_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            mode_left  = $urandom_range(20, 120);
         end
         mode_left--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            case (stall_mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 3) == 0);
               default: begin
                  if (run_left == 0) begin
                     run_stall = !run_stall;
                     run_left  = run_stall ? $urandom_range(1, 15) : $urandom_range(1, 10);
                  end
                  run_left--;
                  rsp_stall <= run_stall;
               end
            endcase
         end
      end
   end

   // Compare each accepted output word with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_iq.size() == 0) begin
            $error("output word with nothing predicted: i=%0d q=%0d batch_end=%0b",
                   rsp_filtered_i, rsp_filtered_q, rsp_batch_end_out);
            fail_count++;
         end else begin
            oldest = expected_iq.pop_front();
            if (rsp_filtered_i !== oldest.fi) begin
               $error("filtered_i: expected %0d, got %0d", oldest.fi, rsp_filtered_i);
               fail_count++;
            end
            if (rsp_filtered_q !== oldest.fq) begin
               $error("filtered_q: expected %0d, got %0d", oldest.fq, rsp_filtered_q);
               fail_count++;
            end
            if (rsp_batch_end_out !== oldest.be) begin
               $error("batch_end_out: expected %0b, got %0b", oldest.be, rsp_batch_end_out);
               fail_count++;
            end
         end
      end
   end

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_opcode     = OP_FILTER;
      req_sample_i   = '0;
      req_sample_q   = '0;
      req_coef_index = '0;
      req_coef_value = '0;
      req_batch_end  = 1'b0;
      csr_we         = 1'b0;
      csr_wdata      = 1'b0;
      fail_count     = 0;
      sender_gaps    = 1'b1;
      burst_left     = 0;
      hold_request   = 1'b0;
      bypass_on      = 1'b1;
      tap_ptr        = 0;
      for (int t = 0; t < TAPS; t++) begin
         tap_hist_i[t] = '0;
         tap_hist_q[t] = '0;
         tap_coef[t]   = '0;
      end
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_bypass_passthrough();
      test_fir_directed();
      test_random_traffic();
      test_output_backpressure();

      drain_outputs();
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
